FILE: src/lrse_pkg.sv
// ----------------------------------------------------------------------------
// lrse_pkg
// shared types and constants of the lr shift-reduce parse engine
// ----------------------------------------------------------------------------
package lrse_pkg;

    localparam int NUM_STATES     = 256;
    localparam int NUM_SYMBOLS    = 64;
    localparam int STACK_DEPTH    = 1024;
    localparam int MAX_REDUCE_RUN = 32;

    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int CNT_W    = STACK_AW + 1;
    localparam int RED_W    = $clog2(MAX_REDUCE_RUN + 1);
    localparam int TBL_AW   = 14;

    typedef enum logic [1:0] {
        FN_WR_ACT  = 2'd0,
        FN_WR_GOTO = 2'd1,
        FN_TOKEN   = 2'd2,
        FN_RESTART = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        AK_ERROR  = 2'd0,
        AK_SHIFT  = 2'd1,
        AK_REDUCE = 2'd2,
        AK_ACCEPT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        EV_SHIFT  = 3'd0,
        EV_REDUCE = 3'd1,
        EV_ACCEPT = 3'd2,
        EV_ERROR  = 3'd3,
        EV_DONE   = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_NO_ACTION  = 3'd1,
        ERR_UNDERFLOW  = 3'd2,
        ERR_EMPTY      = 3'd3,
        ERR_OVERFLOW   = 3'd4,
        ERR_FINISHED   = 3'd5,
        ERR_REDUCE_RUN = 3'd6
    } t_err;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACT_RD,
        ST_ACT_DEC,
        ST_STK_RD,
        ST_GOTO,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] tbl_state;
        logic [5:0] tbl_symbol;
        logic [1:0] act_kind;
        logic [7:0] act_target;
        logic [3:0] act_rhs_len;
        logic [5:0] token_id;
    } t_in;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  error_code;
        logic [7:0]  new_state;
        logic [5:0]  rule_lhs;
        logic [3:0]  rule_len;
        logic [10:0] stack_depth;
        logic        last;
    } t_out;

    typedef struct packed {
        logic   ld_item;
        logic   rd_act;
        logic   pop;
        logic   rd_stk;
        logic   rd_goto;
        logic   push_shift;
        logic   push_goto;
        logic   inc_red;
        logic   set_fin;
        logic   emit;
        t_event emit_ev;
        t_err   emit_err;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  fin;
        logic  out_free;
        t_kind kind;
        logic  cnt_bad;
        logic  full;
        logic  run_max;
        logic  rlen_gt;
        logic  pop_empty;
        logic  lhs_oor;
    } t_status;

endpackage

FILE: src/lr_shift_reduce_engine.sv
// ----------------------------------------------------------------------------
// lr_shift_reduce_engine
// table-driven lr parse engine with action table, goto table and state stack
// ----------------------------------------------------------------------------
// One beat is taken at a time. A table write or restart gives its done result
// in the cycle after it is taken and the engine is ready again as soon as the
// output register is free. A token goes through an action read and decode, and
// each reduction adds a stack read, a goto read, a push and a new action read
// and decode; the steps follow the registered reads of the action, stack and
// goto memories. Results wait in one output register; the engine stalls while
// it is full and not taken. No clearing pass is needed after reset; table
// entries must be written before they are used.
module lr_shift_reduce_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  lrse_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output lrse_pkg::t_out  o_data
);
    import lrse_pkg::*;

    t_cmd    cmd;
    t_status status;

    lrse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    lrse_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (i_data),
        .i_cmd    (cmd),
        .i_ready  (i_ready),
        .o_status (status),
        .o_valid  (o_valid),
        .o_data   (o_data)
    );

`ifndef SYNTHESIS
    a_reduce_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.event_res == EV_REDUCE |-> !o_data.last)
        else $error("reduce result marked last");

    a_error_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.event_res == EV_ERROR |-> o_data.error_code != ERR_NONE)
        else $error("error result without code");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.stack_depth <= 11'(STACK_DEPTH))
        else $error("stack depth beyond limit");
`endif

endmodule

FILE: src/lrse_dp.sv
// ----------------------------------------------------------------------------
// lrse_dp
// datapath: action and goto tables, state stack, counters and result register
// ----------------------------------------------------------------------------
module lrse_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lrse_pkg::t_in    i_data,
    input  lrse_pkg::t_cmd   i_cmd,
    input  logic             i_ready,
    output lrse_pkg::t_status o_status,
    output logic             o_valid,
    output lrse_pkg::t_out   o_data
);
    import lrse_pkg::*;

    logic [13:0] action_mem [1 << TBL_AW];
    logic [7:0]  goto_mem [1 << TBL_AW];
    logic [7:0]  stack_mem [STACK_DEPTH];

    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_top;
    logic [5:0]       r_tok;
    logic             r_fin;
    logic [RED_W-1:0] r_red;
    logic [13:0]      r_act;
    logic [7:0]       r_stk;
    logic             r_stk_zero;
    logic [7:0]       r_goto;
    logic             r_ovalid;
    t_out             r_out, n_out;

    logic [7:0]       a_tgt;
    logic [3:0]       a_len;
    logic [CNT_W-1:0] pop_cnt;
    logic [7:0]       stk_state;
    logic [CNT_W-1:0] rd_idx;
    t_func            in_func;

    assign a_tgt     = r_act[11:4];
    assign a_len     = r_act[3:0];
    assign pop_cnt   = r_count - CNT_W'(a_len);
    assign stk_state = r_stk_zero ? 8'd0 : r_stk;
    assign rd_idx    = r_count - CNT_W'(1);
    assign in_func   = t_func'(i_data.func);

    always_comb begin
        o_status.func      = in_func;
        o_status.fin       = r_fin;
        o_status.out_free  = !r_ovalid || i_ready;
        o_status.kind      = t_kind'(r_act[13:12]);
        o_status.cnt_bad   = (r_count == '0) || (r_count > CNT_W'(STACK_DEPTH));
        o_status.full      = r_count >= CNT_W'(STACK_DEPTH);
        o_status.run_max   = r_red >= RED_W'(MAX_REDUCE_RUN);
        o_status.rlen_gt   = CNT_W'(a_len) > r_count;
        o_status.pop_empty = pop_cnt == '0;
        o_status.lhs_oor   = (int'(a_tgt) >= NUM_SYMBOLS) ||
                             (int'(stk_state) >= NUM_STATES);
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.ld_item && in_func == FN_RESTART) begin
            n_count = CNT_W'(1);
        end else if (i_cmd.push_shift || i_cmd.push_goto) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = pop_cnt;
        end
    end

    always_comb begin
        n_out             = '0;
        n_out.event_res   = i_cmd.emit_ev;
        n_out.error_code  = i_cmd.emit_err;
        n_out.stack_depth = 11'(n_count);
        n_out.last        = (i_cmd.emit_ev != EV_REDUCE);
        if (i_cmd.emit_ev == EV_SHIFT) begin
            n_out.new_state = a_tgt;
        end else if (i_cmd.emit_ev == EV_REDUCE) begin
            n_out.new_state = r_goto;
            n_out.rule_lhs  = a_tgt[5:0];
            n_out.rule_len  = a_len;
        end
    end

    // table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item && in_func == FN_WR_ACT) begin
            action_mem[{i_data.tbl_state, i_data.tbl_symbol}] <=
                {i_data.act_kind, i_data.act_target, i_data.act_rhs_len};
        end
        if (i_cmd.rd_act) begin
            r_act <= action_mem[{r_top, r_tok}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item && in_func == FN_WR_GOTO) begin
            goto_mem[{i_data.tbl_state, i_data.tbl_symbol}] <= i_data.act_target;
        end
        if (i_cmd.rd_goto) begin
            r_goto <= goto_mem[{stk_state, a_tgt[5:0]}];
        end
    end

    // state stack, a read of entry 0 always gives state 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_shift) begin
            stack_mem[r_count[STACK_AW-1:0]] <= a_tgt;
        end else if (i_cmd.push_goto) begin
            stack_mem[r_count[STACK_AW-1:0]] <= r_goto;
        end
        if (i_cmd.rd_stk) begin
            r_stk      <= stack_mem[rd_idx[STACK_AW-1:0]];
            r_stk_zero <= (rd_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_tok <= i_data.token_id;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= CNT_W'(1);
            r_top    <= '0;
            r_fin    <= 1'b0;
            r_red    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.ld_item && in_func == FN_RESTART) begin
                r_top <= '0;
                r_fin <= 1'b0;
            end else begin
                if (i_cmd.push_shift) begin
                    r_top <= a_tgt;
                end else if (i_cmd.push_goto) begin
                    r_top <= r_goto;
                end
                if (i_cmd.set_fin) begin
                    r_fin <= 1'b1;
                end
            end
            if (i_cmd.ld_item) begin
                r_red <= '0;
            end else if (i_cmd.inc_red) begin
                r_red <= r_red + RED_W'(1);
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

FILE: src/lrse_ctrl.sv
// ----------------------------------------------------------------------------
// lrse_ctrl
// controller: sequences table lookups, pops and pushes for each beat
// ----------------------------------------------------------------------------
module lrse_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lrse_pkg::t_status i_status,
    output logic              o_ready,
    output lrse_pkg::t_cmd    o_cmd
);
    import lrse_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit_ev  = EV_DONE;
        o_cmd.emit_err = ERR_NONE;
        o_ready = (r_state == ST_IDLE) && i_status.out_free;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.ld_item = 1'b1;
                    if (i_status.func == FN_TOKEN) begin
                        if (i_status.fin) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_ev  = EV_ERROR;
                            o_cmd.emit_err = ERR_FINISHED;
                        end else begin
                            n_state = ST_ACT_RD;
                        end
                    end else begin
                        o_cmd.emit = 1'b1;
                    end
                end
            end
            ST_ACT_RD: begin
                o_cmd.rd_act = 1'b1;
                n_state = ST_ACT_DEC;
            end
            ST_ACT_DEC: begin
                if (i_status.out_free) begin
                    n_state        = ST_IDLE;
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_ev  = EV_ERROR;
                    o_cmd.set_fin  = 1'b1;
                    if (i_status.cnt_bad) begin
                        o_cmd.emit_err = ERR_EMPTY;
                    end else begin
                        unique case (i_status.kind)
                            AK_SHIFT: begin
                                if (i_status.full) begin
                                    o_cmd.emit_err = ERR_OVERFLOW;
                                end else begin
                                    o_cmd.set_fin    = 1'b0;
                                    o_cmd.push_shift = 1'b1;
                                    o_cmd.emit_ev    = EV_SHIFT;
                                end
                            end
                            AK_ACCEPT: begin
                                o_cmd.emit_ev = EV_ACCEPT;
                            end
                            AK_REDUCE: begin
                                if (i_status.run_max) begin
                                    o_cmd.emit_err = ERR_REDUCE_RUN;
                                end else if (i_status.rlen_gt) begin
                                    o_cmd.emit_err = ERR_UNDERFLOW;
                                end else begin
                                    o_cmd.pop = 1'b1;
                                    if (i_status.pop_empty) begin
                                        o_cmd.emit_err = ERR_EMPTY;
                                    end else begin
                                        o_cmd.emit    = 1'b0;
                                        o_cmd.set_fin = 1'b0;
                                        n_state       = ST_STK_RD;
                                    end
                                end
                            end
                            default: begin
                                o_cmd.emit_err = ERR_NO_ACTION;
                            end
                        endcase
                    end
                end
            end
            ST_STK_RD: begin
                o_cmd.rd_stk = 1'b1;
                n_state = ST_GOTO;
            end
            ST_GOTO: begin
                if (i_status.lhs_oor || i_status.full) begin
                    if (i_status.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_ev  = EV_ERROR;
                        o_cmd.emit_err = i_status.lhs_oor ? ERR_NO_ACTION : ERR_OVERFLOW;
                        o_cmd.set_fin  = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    o_cmd.rd_goto = 1'b1;
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push_goto = 1'b1;
                    o_cmd.inc_red   = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_ev   = EV_REDUCE;
                    n_state         = ST_ACT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: verif/lr_shift_reduce_engine_tb.sv
// ----------------------------------------------------------------------------
// lr_shift_reduce_engine_tb
// self-checking bench: random grammars and token streams against a predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lr_shift_reduce_engine_tb;
    import lrse_pkg::*;

    class parse_scoreboard;
        logic [13:0] act_tbl [NUM_STATES*NUM_SYMBOLS];
        logic [7:0]  goto_tbl [NUM_STATES*NUM_SYMBOLS];
        logic [7:0]  stk [STACK_DEPTH];
        int          depth;
        bit          finished;
        t_out        pending[$];
        int          mismatches;

        function new();
            depth = 1;
            stk[0] = 8'd0;
            finished = 0;
            mismatches = 0;
        endfunction

        function void put(t_event ev, t_err er, logic [7:0] ns, logic [5:0] lhs,
                          logic [3:0] len, bit lst);
            t_out r;
            r.event_res = ev;
            r.error_code = er;
            r.new_state = ns;
            r.rule_lhs = lhs;
            r.rule_len = len;
            r.stack_depth = depth[10:0];
            r.last = lst;
            pending.push_back(r);
        endfunction

        function void fail_with(t_err er);
            finished = 1;
            put(EV_ERROR, er, '0, '0, '0, 1'b1);
        endfunction

        function void note_beat(t_in b);
            int s, idx, reds, kind, tgt, len, g;
            reds = 0;
            if (b.func == FN_WR_ACT || b.func == FN_WR_GOTO) begin
                idx = b.tbl_state * NUM_SYMBOLS + b.tbl_symbol;
                if (b.func == FN_WR_ACT)
                    act_tbl[idx] = {b.act_kind, b.act_target, b.act_rhs_len};
                else
                    goto_tbl[idx] = b.act_target;
                put(EV_DONE, ERR_NONE, '0, '0, '0, 1'b1);
                return;
            end
            if (b.func == FN_RESTART) begin
                stk[0] = 8'd0;
                depth = 1;
                finished = 0;
                put(EV_DONE, ERR_NONE, '0, '0, '0, 1'b1);
                return;
            end
            if (finished) begin
                put(EV_ERROR, ERR_FINISHED, '0, '0, '0, 1'b1);
                return;
            end
            forever begin
                if (depth == 0 || depth > STACK_DEPTH) begin
                    fail_with(ERR_EMPTY);
                    return;
                end
                s = stk[depth-1];
                idx = s * NUM_SYMBOLS + b.token_id;
                kind = act_tbl[idx][13:12];
                tgt = act_tbl[idx][11:4];
                len = act_tbl[idx][3:0];
                if (kind == AK_SHIFT) begin
                    if (depth >= STACK_DEPTH) begin
                        fail_with(ERR_OVERFLOW);
                        return;
                    end
                    stk[depth] = 8'(tgt);
                    depth++;
                    put(EV_SHIFT, ERR_NONE, 8'(tgt), '0, '0, 1'b1);
                    return;
                end
                if (kind == AK_ACCEPT) begin
                    finished = 1;
                    put(EV_ACCEPT, ERR_NONE, '0, '0, '0, 1'b1);
                    return;
                end
                if (kind == AK_ERROR) begin
                    fail_with(ERR_NO_ACTION);
                    return;
                end
                if (reds >= MAX_REDUCE_RUN) begin
                    fail_with(ERR_REDUCE_RUN);
                    return;
                end
                if (len > depth) begin
                    fail_with(ERR_UNDERFLOW);
                    return;
                end
                depth -= len;
                if (depth == 0) begin
                    fail_with(ERR_EMPTY);
                    return;
                end
                s = stk[depth-1];
                if (tgt >= NUM_SYMBOLS) begin
                    fail_with(ERR_NO_ACTION);
                    return;
                end
                if (depth >= STACK_DEPTH) begin
                    fail_with(ERR_OVERFLOW);
                    return;
                end
                g = goto_tbl[s * NUM_SYMBOLS + tgt];
                stk[depth] = 8'(g);
                depth++;
                put(EV_REDUCE, ERR_NONE, 8'(g), tgt[5:0], 4'(len), 1'b0);
                reds++;
            end
        endfunction

        function void check_beat(t_out got);
            t_out exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p got %p", exp_r, got);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    t_in  i_data = '0;
    logic o_valid;
    logic i_ready = 0;
    t_out o_data;

    parse_scoreboard sb;
    int stall_mode = 0;

    always #10 i_clk = ~i_clk;

    lr_shift_reduce_engine i_dut (.*);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_beat(i_data);
            if (o_valid && i_ready) sb.check_beat(o_data);
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= (r < 70);
            default: i_ready <= (r < 20);
        endcase
    end

    int burst_left = 0;

    task automatic send_beat(t_in b);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_data <= b;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic wr_act(int st, int sym, t_kind k, int tgt, int len);
        t_in b;
        b = '0;
        b.func = FN_WR_ACT;
        b.tbl_state = 8'(st);
        b.tbl_symbol = 6'(sym);
        b.act_kind = k;
        b.act_target = 8'(tgt);
        b.act_rhs_len = 4'(len);
        b.token_id = 6'($urandom);
        send_beat(b);
    endtask

    task automatic wr_goto(int st, int sym, int tgt);
        t_in b;
        b = 36'({$urandom, $urandom});
        b.func = FN_WR_GOTO;
        b.tbl_state = 8'(st);
        b.tbl_symbol = 6'(sym);
        b.act_target = 8'(tgt);
        send_beat(b);
    endtask

    task automatic send_token(int tok);
        t_in b;
        b = 36'({$urandom, $urandom});
        b.func = FN_TOKEN;
        b.token_id = 6'(tok);
        send_beat(b);
    endtask

    task automatic restart_parse();
        t_in b;
        b = 36'({$urandom, $urandom});
        b.func = FN_RESTART;
        send_beat(b);
    endtask

    // fill the action and goto region in states 0..3, symbols 0..3
    task automatic fill_tables();
        for (int st = 0; st < 4; st++)
            for (int sym = 0; sym < 4; sym++) begin
                wr_act(st, sym, AK_ERROR, $urandom, $urandom);
                wr_goto(st, sym, 0);
            end
    endtask

    task automatic random_tables(int n);
        t_kind k;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            k = r < 5 ? AK_SHIFT : (r < 8 ? AK_REDUCE : (r < 9 ? AK_ACCEPT : AK_ERROR));
            if (k == AK_REDUCE)
                wr_act($urandom_range(0, 3), $urandom_range(0, 3), k,
                       $urandom_range(0, 7) == 0 ? $urandom_range(64, 255)
                                                 : $urandom_range(0, 3),
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                                                 : $urandom_range(0, 2));
            else
                wr_act($urandom_range(0, 3), $urandom_range(0, 3), k,
                       $urandom_range(0, 3), $urandom);
            if ($urandom_range(0, 1))
                wr_goto($urandom_range(0, 3), $urandom_range(0, 3),
                        $urandom_range(0, 3));
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        stall_mode = 0;
        fill_tables();

        // directed: shift at the top field values, accept, each error
        stall_mode = 1;
        wr_act(0, 63, AK_SHIFT, 255, 15);
        wr_act(255, 5, AK_ERROR, 255, 15);
        send_token(63);
        send_token(5);
        send_token(63);
        restart_parse();
        wr_act(0, 1, AK_ACCEPT, 0, 0);
        send_token(1);
        send_token(1);
        restart_parse();
        wr_act(0, 2, AK_REDUCE, 3, 5);
        send_token(2);
        restart_parse();
        wr_act(0, 3, AK_REDUCE, 3, 1);
        send_token(3);
        restart_parse();
        wr_act(0, 4, AK_SHIFT, 1, 0);
        wr_act(1, 5, AK_REDUCE, 200, 1);
        send_token(4);
        send_token(5);
        restart_parse();
        // a reduce that loops until the run limit
        wr_act(2, 6, AK_REDUCE, 7, 1);
        wr_goto(0, 7, 2);
        wr_act(0, 6, AK_SHIFT, 2, 0);
        send_token(6);
        send_token(6);
        restart_parse();
        // overflow: a chain of empty reductions through states 16 to 46
        wr_act(0, 9, AK_SHIFT, 16, 0);
        for (int st = 16; st < 46; st++) begin
            wr_act(st, 9, AK_REDUCE, 9, 0);
            wr_goto(st, 9, st + 1);
        end
        wr_act(46, 9, AK_SHIFT, 16, 0);
        stall_mode = 0;
        repeat (35) send_token(9);
        restart_parse();

        // random grammars in states 0..3, symbols 0..3, with token streams
        for (int phase = 0; phase < 8; phase++) begin
            stall_mode = phase % 3;
            random_tables(8);
            restart_parse();
            for (int t = 0; t < 18; t++) begin
                if ($urandom_range(0, 15) == 0) restart_parse();
                send_token($urandom_range(0, 3));
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
        stall_mode = 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #30ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
